[hw/rtl/hgrp_pkg.sv]
// Shared types, constants and helpers for the hexapod gait relative-phase unit.
// No dependencies; every other file in hw/rtl depends on this package.
package hgrp_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int NUM_LEGS         = 6;
  localparam int XY_W             = 33;   // holds |v| * 2^14 * CORDIC gain * sqrt(2)

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // leg k offset, round(k/6 turn) in Q0.16
  localparam logic [15:0] LEG_OFFSET [NUM_LEGS] = '{
    16'd0, 16'd10923, 16'd21845, 16'd32768, 16'd43691, 16'd54613
  };

  // quarter-cycle bias plus rounding half; even legs (odd index) get a half cycle more
  localparam logic [31:0] BIAS_ODD_LEG  = 32'h4000_8000;
  localparam logic [31:0] BIAS_EVEN_LEG = 32'hC000_8000;

  // ramp breakpoints (a < B tests) and levels, g in units of 2^-16
  localparam logic [15:0]        RAMP_B0   = 16'd5462;
  localparam logic [15:0]        RAMP_B1   = 16'd27307;
  localparam logic [15:0]        RAMP_B2   = 16'd38230;
  localparam logic [15:0]        RAMP_B3   = 16'd60075;
  localparam logic signed [19:0] G_LOW     = -20'sd98304;
  localparam logic signed [19:0] G_HIGH    = 20'sd32768;
  localparam logic signed [19:0] G_UP_OFF  = 20'sd131072;
  localparam logic signed [19:0] G_DN_OFF  = 20'sd262144;

  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [31:0] ROUND_Q16 = 32'h0000_8000;
  localparam logic signed [16:0] DUTY_MID = 17'sd32768;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [15:0]        support_duty;
  } sample_t;

  typedef struct packed {
    logic [15:0] phase_leg1;
    logic [15:0] phase_leg2;
    logic [15:0] phase_leg3;
    logic [15:0] phase_leg4;
    logic [15:0] phase_leg5;
    logic [15:0] phase_leg6;
  } phases_t;

  // CORDIC working vector handed from cell to cell
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [31:0]            z;
    logic                   zero;
    logic [15:0]            duty;
  } cordic_t;

  function automatic logic signed [17:0] ramp(input logic [15:0] a);
    logic [19:0]        a6u;
    logic signed [19:0] a6;
    logic signed [19:0] g;
    a6u = ({4'b0, a} << 2) + ({4'b0, a} << 1);
    a6  = signed'(a6u);
    if (a < RAMP_B0) begin
      g = G_LOW;
    end else if (a < RAMP_B1) begin
      g = a6 - G_UP_OFF;
    end else if (a < RAMP_B2) begin
      g = G_HIGH;
    end else if (a < RAMP_B3) begin
      g = G_DN_OFF - a6;
    end else begin
      g = G_LOW;
    end
    return g[17:0];
  endfunction

endpackage

[hw/rtl/hexapod_gait_relative_phase_unit.sv]
// Top level of the hexapod gait relative-phase unit: input register, CORDIC cell chain,
// phase stages. Depends on hgrp_pkg, hgrp_cordic_cell, hgrp_phase_stage.
//
// Takes one velocity/duty sample per clock and returns the six leg relative phases
// for it. Throughput is one sample per cycle while phases_ready keeps the output moving;
// each sample passes the input register, one cell per micro-rotation and three phase stages.
// Every stage has its own valid bit, so empty stages fill while the output is held,
// and sample_ready stays high whenever the result is taken or no result is waiting.
module hexapod_gait_relative_phase_unit #(
  parameter int CORDIC_STEPS = hgrp_pkg::CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  hgrp_pkg::sample_t sample,
  output logic              phases_valid,
  input  logic              phases_ready,
  output hgrp_pkg::phases_t phases
);
  import hgrp_pkg::*;

  localparam int STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

  logic                   chain_valid [STEPS+1];
  logic                   chain_ready [STEPS+1];
  cordic_t                chain_data  [STEPS+1];
  cordic_t                pre;
  logic                   in_vld;
  cordic_t                in_vec;
  logic signed [XY_W-1:0] x0;
  logic signed [XY_W-1:0] y0;

  // pre-rotation: scale by 2^14, fold the left half plane over by a half turn
  always_comb begin
    x0       = {{(XY_W-30){sample.vel_x[15]}}, sample.vel_x, 14'b0};
    y0       = {{(XY_W-30){sample.vel_y[15]}}, sample.vel_y, 14'b0};
    pre.zero = (sample.vel_x == '0) && (sample.vel_y == '0);
    pre.duty = sample.support_duty;
    if (sample.vel_x[15]) begin
      pre.x = -x0;
      pre.y = -y0;
      pre.z = HALF_TURN;
    end else begin
      pre.x = x0;
      pre.y = y0;
      pre.z = '0;
    end
  end

  assign sample_ready   = !in_vld || chain_ready[0];
  assign chain_valid[0] = in_vld;
  assign chain_data[0]  = in_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (sample_ready) begin
      in_vld <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      in_vec <= pre;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    hgrp_cordic_cell #(
      .SHIFT(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .up_valid(chain_valid[i]),
      .up_ready(chain_ready[i]),
      .up_data (chain_data[i]),
      .dn_valid(chain_valid[i+1]),
      .dn_ready(chain_ready[i+1]),
      .dn_data (chain_data[i+1])
    );
  end

  hgrp_phase_stage u_phase (
    .clk     (clk),
    .rst     (rst),
    .up_valid(chain_valid[STEPS]),
    .up_ready(chain_ready[STEPS]),
    .up_data (chain_data[STEPS]),
    .dn_valid(phases_valid),
    .dn_ready(phases_ready),
    .dn_data (phases)
  );

endmodule

[hw/rtl/hgrp_cordic_cell.sv]
// One vectoring CORDIC micro-rotation with its own pipeline register.
// Depends on hgrp_pkg (cordic_t, ATAN_TURNS).
module hgrp_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  hgrp_pkg::cordic_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output hgrp_pkg::cordic_t dn_data
);
  import hgrp_pkg::*;

  logic                   vld;
  cordic_t                vec;
  cordic_t                rot;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;

  assign up_ready = !vld || dn_ready;
  assign dn_valid = vld;
  assign dn_data  = vec;

  always_comb begin
    xs  = up_data.x >>> SHIFT;
    ys  = up_data.y >>> SHIFT;
    rot = up_data;
    if (up_data.y > 0) begin
      rot.x = up_data.x + ys;
      rot.y = up_data.y - xs;
      rot.z = up_data.z + ATAN_TURNS[SHIFT];
    end else begin
      rot.x = up_data.x - ys;
      rot.y = up_data.y + xs;
      rot.z = up_data.z - ATAN_TURNS[SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      vec <= rot;
    end
  end

endmodule

[hw/rtl/hgrp_phase_stage.sv]
// Crab angle rounding, per-leg ramp and duty-factor scaling, three registered stages.
// Depends on hgrp_pkg (cordic_t, phases_t, ramp, leg constants).
module hgrp_phase_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  hgrp_pkg::cordic_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output hgrp_pkg::phases_t dn_data
);
  import hgrp_pkg::*;

  logic               v1, v2, v3;
  logic               r1, r2, r3;
  logic [15:0]        angle_q;
  logic signed [16:0] d1_q;
  logic signed [16:0] d2_q;
  logic signed [17:0] g_q [NUM_LEGS];
  logic [15:0]        ph_q [NUM_LEGS];
  logic [31:0]        zr;
  logic [15:0]        leg_a [NUM_LEGS];
  logic signed [34:0] prod [NUM_LEGS];
  logic [31:0]        p [NUM_LEGS];

  assign r3       = !v3 || dn_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign up_ready = r1;
  assign dn_valid = v3;

  assign zr = up_data.z + ROUND_Q16;

  always_comb begin
    for (int k = 0; k < NUM_LEGS; k++) begin
      leg_a[k] = angle_q - LEG_OFFSET[k];
      prod[k]  = g_q[k] * d2_q;
      p[k]     = prod[k][31:0] + (k[0] ? BIAS_EVEN_LEG : BIAS_ODD_LEG);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= up_valid;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && r1) begin
      angle_q <= up_data.zero ? 16'd0 : zr[31:16];
      d1_q    <= signed'({1'b0, up_data.duty}) - DUTY_MID;
    end
    if (v1 && r2) begin
      for (int k = 0; k < NUM_LEGS; k++) begin
        g_q[k] <= ramp(leg_a[k]);
      end
      d2_q <= d1_q;
    end
    if (v2 && r3) begin
      for (int k = 0; k < NUM_LEGS; k++) begin
        ph_q[k] <= p[k][31:16];
      end
    end
  end

  assign dn_data.phase_leg1 = ph_q[0];
  assign dn_data.phase_leg2 = ph_q[1];
  assign dn_data.phase_leg3 = ph_q[2];
  assign dn_data.phase_leg4 = ph_q[3];
  assign dn_data.phase_leg5 = ph_q[4];
  assign dn_data.phase_leg6 = ph_q[5];

endmodule

[hw/rtl/hgrp_checker.sv]
// Port-level checks for hexapod_gait_relative_phase_unit, bound to the top level.
// Depends on hgrp_pkg for the payload types.
module hgrp_checker (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_ready,
  input hgrp_pkg::sample_t sample,
  input logic              phases_valid,
  input logic              phases_ready,
  input hgrp_pkg::phases_t phases
);

  // nothing leaves right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !phases_valid)
    else $error("phases_valid high right after reset");

  // a free output means the whole chain can move, so input is taken
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (phases_ready || !phases_valid) |-> sample_ready)
    else $error("sample_ready low while output side is free");

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    phases_valid && !phases_ready |=> phases_valid && $stable(phases))
    else $error("result changed or dropped before transfer");

  // a waiting sample stays put until its transfer
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_ready |=> sample_valid && $stable(sample))
    else $error("sample changed or dropped before transfer");

endmodule

bind hexapod_gait_relative_phase_unit hgrp_checker u_hgrp_checker (.*);
